// File: rtl/core/mesi_pkg.sv
// ----------------------------------------------------------------------------
// mesi_pkg
// Shared types and defaults for the two-core MESI coherence controller.
// ----------------------------------------------------------------------------
package mesi_pkg;

	// Default geometry; set count and line size are powers of two
	localparam int unsigned NUM_SETS_DEF   = 256;
	localparam int unsigned LINE_BYTES_DEF = 64;
	localparam int unsigned ADDR_BITS_DEF  = 32;

	typedef enum logic {
		CMD_READ  = 1'b0,
		CMD_WRITE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		MESI_I = 2'd0,
		MESI_S = 2'd1,
		MESI_E = 2'd2,
		MESI_M = 2'd3
	} mesi_state_t;

	typedef enum logic [1:0] {
		BUS_NONE = 2'd0,
		BUS_RD   = 2'd1,
		BUS_RDX  = 2'd2,
		BUS_UPGR = 2'd3
	} bus_op_t;

	// Outcome of one coherence lookup
	typedef struct packed {
		mesi_state_t own_next;
		mesi_state_t oth_next;
		logic        hit;
		bus_op_t     bus_op;
		logic        wb;
		logic        inv;
	} xfer_t;

endpackage

// File: rtl/core/mesi_req_if.sv
// ----------------------------------------------------------------------------
// mesi_req_if
// Access request channel: read or write from one core at a byte address.
// ----------------------------------------------------------------------------
interface mesi_req_if;
	logic               valid;
	logic               ready;
	mesi_pkg::cmd_t     cmd;
	logic               core;
	logic [31:0]        address;

	modport source (output valid, output cmd, output core, output address, input ready);
	modport sink   (input valid, input cmd, input core, input address, output ready);
endinterface

// File: rtl/core/mesi_rsp_if.sv
// ----------------------------------------------------------------------------
// mesi_rsp_if
// Coherence result channel: new states, hit, bus operation, snoop effects.
// ----------------------------------------------------------------------------
interface mesi_rsp_if;
	logic                  valid;
	logic                  ready;
	mesi_pkg::mesi_state_t requester_state;
	logic                  hit;
	mesi_pkg::bus_op_t     bus_op;
	mesi_pkg::mesi_state_t other_state;
	logic                  snoop_writeback;
	logic                  snoop_invalidate;

	modport source (output valid, output requester_state, output hit, output bus_op,
		output other_state, output snoop_writeback, output snoop_invalidate,
		input ready);
	modport sink   (input valid, input requester_state, input hit, input bus_op,
		input other_state, input snoop_writeback, input snoop_invalidate,
		output ready);
endinterface

// File: rtl/core/mesi_line_ram.sv
// ----------------------------------------------------------------------------
// mesi_line_ram
// One row per set holding tag and state of both cores; registered read,
// single write port, and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module mesi_line_ram #(
	parameter int unsigned NUM_SETS = mesi_pkg::NUM_SETS_DEF,
	parameter int unsigned ROW_W    = 40,
	localparam int unsigned SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1
) (
	input  logic             clk,
	input  logic             arst_n,
	output logic             busy,
	input  logic             rd_en,
	input  logic [SET_W-1:0] rd_addr,
	output logic [ROW_W-1:0] rd_data,
	input  logic             wr_en,
	input  logic [SET_W-1:0] wr_addr,
	input  logic [ROW_W-1:0] wr_data
);

	logic [ROW_W-1:0] mem [NUM_SETS];
	logic [ROW_W-1:0] rd_data_q;
	logic             clr_q;
	logic [SET_W-1:0] clr_cnt_q;

	// sweep: all-zero row means Invalid for both cores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == SET_W'(NUM_SETS - 1)) begin
				clr_q <= 1'b0;
			end
			clr_cnt_q <= clr_cnt_q + SET_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_q;

endmodule

// File: rtl/core/mesi_xfer.sv
// ----------------------------------------------------------------------------
// mesi_xfer
// MESI transition logic for one access: requester lookup plus snoop.
// ----------------------------------------------------------------------------
module mesi_xfer #(
	parameter int unsigned TAG_W = 18
) (
	input  mesi_pkg::cmd_t        cmd,
	input  logic [TAG_W-1:0]      tag,
	input  mesi_pkg::mesi_state_t own_state,
	input  logic [TAG_W-1:0]      own_tag,
	input  mesi_pkg::mesi_state_t oth_state,
	input  logic [TAG_W-1:0]      oth_tag,
	output mesi_pkg::xfer_t       res
);

	logic own_has;
	logic oth_has;

	assign own_has = (own_state != mesi_pkg::MESI_I) && (own_tag == tag);
	assign oth_has = (oth_state != mesi_pkg::MESI_I) && (oth_tag == tag);

	always_comb begin
		res          = '0;
		res.own_next = own_state;
		res.oth_next = oth_state;
		res.hit      = own_has;
		res.bus_op   = mesi_pkg::BUS_NONE;
		if (cmd == mesi_pkg::CMD_READ) begin
			if (!own_has) begin
				res.bus_op = mesi_pkg::BUS_RD;
				if (oth_has) begin
					res.wb       = (oth_state == mesi_pkg::MESI_M);
					res.oth_next = mesi_pkg::MESI_S;
					res.own_next = mesi_pkg::MESI_S;
				end else begin
					res.own_next = mesi_pkg::MESI_E;
				end
			end
		end else if (own_has) begin
			case (own_state)
				mesi_pkg::MESI_E: begin
					res.own_next = mesi_pkg::MESI_M;
				end
				mesi_pkg::MESI_S: begin
					res.bus_op = mesi_pkg::BUS_UPGR;
					if (oth_has) begin
						res.oth_next = mesi_pkg::MESI_I;
						res.inv      = 1'b1;
					end
					res.own_next = mesi_pkg::MESI_M;
				end
				default: begin
					res.own_next = own_state;
				end
			endcase
		end else begin
			// write miss: read for ownership, victim dropped silently
			res.bus_op = mesi_pkg::BUS_RDX;
			if (oth_has) begin
				res.wb       = (oth_state == mesi_pkg::MESI_M);
				res.oth_next = mesi_pkg::MESI_I;
				res.inv      = 1'b1;
			end
			res.own_next = mesi_pkg::MESI_M;
		end
	end

endmodule

// File: rtl/core/two_core_mesi_coherence_controller_core.sv
// ----------------------------------------------------------------------------
// two_core_mesi_coherence_controller_core
// Two-core MESI controller over direct-mapped tag/state arrays, one access
// per cycle while rsp is not stalled and no clearing sweep runs.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    cmd, core, address
//  rsp      out  valid/ready    requester_state, hit, bus_op, other_state,
//                               snoop_writeback, snoop_invalidate
//
// One transaction per cycle sustained unless rsp stalls; the array read is
// registered on the edge that accepts the request, and the lookup then goes
// into the result register, which drives rsp.valid.
// After reset a sweep clears every set of the state array, with req.ready low.
// A back-to-back access to the same set takes the row just computed from a
// forwarding register, since the array write lands on the same edge.
// A stalled rsp holds the lookup stage; req.ready drops only during the sweep or
// when the result register and lookup stage are both full and rsp is stalled.
// NUM_SETS and LINE_BYTES must be powers of two.
// ----------------------------------------------------------------------------
module two_core_mesi_coherence_controller_core #(
	parameter int unsigned NUM_SETS   = mesi_pkg::NUM_SETS_DEF,
	parameter int unsigned LINE_BYTES = mesi_pkg::LINE_BYTES_DEF,
	parameter int unsigned ADDR_BITS  = mesi_pkg::ADDR_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mesi_req_if.sink   req,
	mesi_rsp_if.source rsp
);

	// address split
	localparam int unsigned OFF_W   = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 0;
	localparam int unsigned SETB    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 0;
	localparam int unsigned SET_W   = (SETB > 0) ? SETB : 1;
	localparam int unsigned EA      = (ADDR_BITS < 32) ? ADDR_BITS : 32;
	localparam int          TAG_RAW = int'(EA) - int'(OFF_W) - int'(SETB);
	localparam int unsigned TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int unsigned HALF_W  = TAG_W + 2;
	localparam int unsigned ROW_W   = 2 * HALF_W;
	localparam logic [32:0] ADDR_SPAN = 33'd1 << EA;
	localparam logic [31:0] ADDR_MASK = ADDR_SPAN[31:0] - 32'd1;
	localparam logic [31:0] SET_MASK  = 32'(NUM_SETS - 1);

	logic              accept;
	logic              adv;
	logic              busy;
	logic [31:0]       addr_m;
	logic [SET_W-1:0]  set_in;
	logic [TAG_W-1:0]  tag_in;

	// lookup stage
	logic              valid_s1;
	mesi_pkg::cmd_t    cmd_s1;
	logic              core_s1;
	logic [SET_W-1:0]  set_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic              fwd_s1;
	logic [ROW_W-1:0]  fwd_row_s1;

	logic [ROW_W-1:0]  rd_row;
	logic [ROW_W-1:0]  row_cur;
	logic [HALF_W-1:0] half0;
	logic [HALF_W-1:0] half1;
	logic [HALF_W-1:0] own_half;
	logic [HALF_W-1:0] oth_half;
	logic [HALF_W-1:0] own_new;
	logic [HALF_W-1:0] oth_new;
	logic [ROW_W-1:0]  new_row;
	mesi_pkg::xfer_t   xfer;

	// result register
	logic              rsp_valid_q;
	mesi_pkg::xfer_t   res_q;

	assign addr_m = req.address & ADDR_MASK;
	assign set_in = SET_W'((addr_m >> OFF_W) & SET_MASK);
	assign tag_in = TAG_W'(addr_m >> (OFF_W + SETB));

	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !busy && (!valid_s1 || adv);
	assign accept    = req.valid && req.ready;

	mesi_line_ram #(
		.NUM_SETS (NUM_SETS),
		.ROW_W    (ROW_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (busy),
		.rd_en   (accept),
		.rd_addr (set_in),
		.rd_data (rd_row),
		.wr_en   (adv),
		.wr_addr (set_s1),
		.wr_data (new_row)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// the row written on the accept edge is not yet visible to the read
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1     <= req.cmd;
			core_s1    <= req.core;
			set_s1     <= set_in;
			tag_s1     <= tag_in;
			fwd_s1     <= adv && (set_in == set_s1);
			fwd_row_s1 <= new_row;
		end
	end

	assign row_cur  = fwd_s1 ? fwd_row_s1 : rd_row;
	assign half0    = row_cur[HALF_W-1:0];
	assign half1    = row_cur[ROW_W-1:HALF_W];
	assign own_half = core_s1 ? half1 : half0;
	assign oth_half = core_s1 ? half0 : half1;

	mesi_xfer #(
		.TAG_W (TAG_W)
	) u_xfer (
		.cmd       (cmd_s1),
		.tag       (tag_s1),
		.own_state (mesi_pkg::mesi_state_t'(own_half[1:0])),
		.own_tag   (own_half[HALF_W-1:2]),
		.oth_state (mesi_pkg::mesi_state_t'(oth_half[1:0])),
		.oth_tag   (oth_half[HALF_W-1:2]),
		.res       (xfer)
	);

	// requester's line always ends valid with the request tag
	assign own_new = {tag_s1, xfer.own_next};
	assign oth_new = {oth_half[HALF_W-1:2], xfer.oth_next};
	assign new_row = core_s1 ? {own_new, oth_new} : {oth_new, own_new};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= xfer;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.requester_state  = res_q.own_next;
	assign rsp.hit              = res_q.hit;
	assign rsp.bus_op           = res_q.bus_op;
	assign rsp.other_state      = res_q.oth_next;
	assign rsp.snoop_writeback  = res_q.wb;
	assign rsp.snoop_invalidate = res_q.inv;

	// a write always leaves the requester owning the line modified
	a_write_to_m: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (cmd_s1 == mesi_pkg::CMD_WRITE) |-> xfer.own_next == mesi_pkg::MESI_M)
		else $error("write did not end in M");

	// exclusive ownership: no other valid copy of the same tag
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (xfer.own_next == mesi_pkg::MESI_M || xfer.own_next == mesi_pkg::MESI_E)
		&& (xfer.oth_next != mesi_pkg::MESI_I) |-> oth_half[HALF_W-1:2] != tag_s1)
		else $error("E/M line also held by other core");

	a_inv_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv && xfer.inv |-> xfer.oth_next == mesi_pkg::MESI_I)
		else $error("invalidate left other line valid");

	a_hit_no_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv && xfer.hit |-> xfer.bus_op != mesi_pkg::BUS_RD && xfer.bus_op != mesi_pkg::BUS_RDX)
		else $error("hit issued a line fill");

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !valid_s1 || $past(valid_s1))
		else $error("transaction accepted during clearing sweep");

endmodule
